// ----- src/apc_pkg.sv -----
// Package for the arithmetic pixel composite core: widths, register codes,
// the stage count, shared types and the two 256-entry color conversion ROMs.
// No dependencies.
`default_nettype none

package apc_pkg;

    localparam int COEF_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int PIXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = PIXEL_W / CHAN_W;

    // Register stages per channel; stage 0 is the input register.
    localparam int APC_STAGES = 8;

    // Datapath widths
    localparam int XK_W   = COEF_W + CHAN_W + 1;   // k2*x, k3*y
    localparam int SUM_W  = XK_W + 1;              // k2*x + k3*y
    localparam int PROD_W = COEF_W + 2 * CHAN_W + 1; // k1*x*y
    localparam int ACC_W  = 43;                    // n minus the k4 term
    localparam int BIAS_W = 42;                    // 2*65025*k4 + den
    localparam int T_W    = ACC_W + 2;             // 2n + den
    localparam int QSHIFT = 17;                    // 2*den = 2^17 * 255

    localparam int unsigned BIAS_MULT = 130050;    // 2 * 255 * 255
    localparam int unsigned ROUND_DEN = 16711680;  // 255 * 65536
    localparam int unsigned U_LIMIT   = 65280;     // 256 * 255

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_PRODUCT = 3'd0,
        CFG_COEF_FIRST   = 3'd1,
        CFG_COEF_SECOND  = 3'd2,
        CFG_COEF_OFFSET  = 3'd3,
        CFG_LINEAR_MODE  = 3'd4
    } cfg_index_t;

    typedef logic [APC_STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [BIAS_W-1:0] bias;
    } coef_t;

    localparam logic [7:0] SRGB_TO_LIN [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,
        8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,
        8'd8,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd11,8'd11,8'd12,8'd12,8'd12,
        8'd13,
        8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,8'd17,8'd18,8'd18,
        8'd19,8'd19,8'd20,
        8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,8'd26,8'd27,8'd27,
        8'd28,8'd29,8'd29,
        8'd30,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,8'd35,8'd36,8'd37,8'd37,8'd38,
        8'd39,8'd40,8'd41,
        8'd41,8'd42,8'd43,8'd44,8'd45,8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd51,
        8'd52,8'd53,8'd54,
        8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,
        8'd68,8'd69,8'd70,
        8'd71,8'd72,8'd73,8'd74,8'd76,8'd77,8'd78,8'd79,8'd80,8'd81,8'd82,8'd84,8'd85,
        8'd86,8'd87,8'd88,
        8'd90,8'd91,8'd92,8'd93,8'd95,8'd96,8'd97,8'd99,8'd100,8'd101,8'd103,8'd104,8'd105,
        8'd107,8'd108,8'd109,
        8'd111,8'd112,8'd114,8'd115,8'd116,8'd118,8'd119,8'd121,8'd122,8'd124,8'd125,8'd127,
        8'd128,8'd130,8'd131,8'd133,
        8'd134,8'd136,8'd138,8'd139,8'd141,8'd142,8'd144,8'd146,8'd147,8'd149,8'd151,8'd152,
        8'd154,8'd156,8'd157,8'd159,
        8'd161,8'd163,8'd164,8'd166,8'd168,8'd170,8'd171,8'd173,8'd175,8'd177,8'd179,8'd181,
        8'd183,8'd184,8'd186,8'd188,
        8'd190,8'd192,8'd194,8'd196,8'd198,8'd200,8'd202,8'd204,8'd206,8'd208,8'd210,8'd212,
        8'd214,8'd216,8'd218,8'd220,
        8'd222,8'd224,8'd226,8'd229,8'd231,8'd233,8'd235,8'd237,8'd239,8'd242,8'd244,8'd246,
        8'd248,8'd250,8'd253,8'd255
    };

    localparam logic [7:0] LIN_TO_SRGB [256] = '{
        8'd0,8'd13,8'd22,8'd28,8'd34,8'd38,8'd42,8'd46,8'd50,8'd53,8'd56,8'd59,8'd61,8'd64,
        8'd66,8'd69,
        8'd71,8'd73,8'd75,8'd77,8'd79,8'd81,8'd83,8'd85,8'd86,8'd88,8'd90,8'd92,8'd93,8'd95,
        8'd96,8'd98,
        8'd99,8'd101,8'd102,8'd104,8'd105,8'd106,8'd108,8'd109,8'd110,8'd112,8'd113,8'd114,
        8'd115,8'd117,8'd118,8'd119,
        8'd120,8'd121,8'd122,8'd124,8'd125,8'd126,8'd127,8'd128,8'd129,8'd130,8'd131,8'd132,
        8'd133,8'd134,8'd135,8'd136,
        8'd137,8'd138,8'd139,8'd140,8'd141,8'd142,8'd143,8'd144,8'd145,8'd146,8'd147,8'd148,
        8'd148,8'd149,8'd150,8'd151,
        8'd152,8'd153,8'd154,8'd155,8'd155,8'd156,8'd157,8'd158,8'd159,8'd159,8'd160,8'd161,
        8'd162,8'd163,8'd163,8'd164,
        8'd165,8'd166,8'd167,8'd167,8'd168,8'd169,8'd170,8'd170,8'd171,8'd172,8'd173,8'd173,
        8'd174,8'd175,8'd175,8'd176,
        8'd177,8'd178,8'd178,8'd179,8'd180,8'd180,8'd181,8'd182,8'd182,8'd183,8'd184,8'd185,
        8'd185,8'd186,8'd187,8'd187,
        8'd188,8'd189,8'd189,8'd190,8'd190,8'd191,8'd192,8'd192,8'd193,8'd194,8'd194,8'd195,
        8'd196,8'd196,8'd197,8'd197,
        8'd198,8'd199,8'd199,8'd200,8'd200,8'd201,8'd202,8'd202,8'd203,8'd203,8'd204,8'd205,
        8'd205,8'd206,8'd206,8'd207,
        8'd208,8'd208,8'd209,8'd209,8'd210,8'd210,8'd211,8'd212,8'd212,8'd213,8'd213,8'd214,
        8'd214,8'd215,8'd215,8'd216,
        8'd216,8'd217,8'd218,8'd218,8'd219,8'd219,8'd220,8'd220,8'd221,8'd221,8'd222,8'd222,
        8'd223,8'd223,8'd224,8'd224,
        8'd225,8'd226,8'd226,8'd227,8'd227,8'd228,8'd228,8'd229,8'd229,8'd230,8'd230,8'd231,
        8'd231,8'd232,8'd232,8'd233,
        8'd233,8'd234,8'd234,8'd235,8'd235,8'd236,8'd236,8'd237,8'd237,8'd238,8'd238,8'd238,
        8'd239,8'd239,8'd240,8'd240,
        8'd241,8'd241,8'd242,8'd242,8'd243,8'd243,8'd244,8'd244,8'd245,8'd245,8'd246,8'd246,
        8'd246,8'd247,8'd247,8'd248,
        8'd248,8'd249,8'd249,8'd250,8'd250,8'd251,8'd251,8'd251,8'd252,8'd252,8'd253,8'd253,
        8'd254,8'd254,8'd255,8'd255
    };

endpackage

`default_nettype wire

// ----- src/apc_channel.sv -----
// One 8-bit channel of the arithmetic composite: eight register stages from
// the input pair to the rounded, clamped and optionally re-encoded result.
// Depends on apc_pkg; stage enables come from the top level.
`default_nettype none

module apc_channel (
    input  wire logic                       clk,
    input  wire apc_pkg::stage_en_t         en,
    input  wire apc_pkg::coef_t             coef,
    input  wire logic                       use_lin,
    input  wire logic [apc_pkg::CHAN_W-1:0] x_in,
    input  wire logic [apc_pkg::CHAN_W-1:0] y_in,
    output logic      [apc_pkg::CHAN_W-1:0] res_out
);
    import apc_pkg::*;

    // stage 0: input, sRGB to linear
    logic [CHAN_W-1:0]        x_reg, x_next;
    logic [CHAN_W-1:0]        y_reg, y_next;
    // stage 1: partial products
    logic [2*CHAN_W-1:0]      xy_reg, xy_next;
    logic signed [XK_W-1:0]   k2x_reg, k2x_next;
    logic signed [XK_W-1:0]   k3y_reg, k3y_next;
    // stage 2: k1*x*y and the linear sum
    logic signed [PROD_W-1:0] m1_reg, m1_next;
    logic signed [SUM_W-1:0]  s_reg, s_next;
    // stage 3: accumulate
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    // stage 4: 2n + den
    logic signed [T_W-1:0]    t_reg, t_next;
    // stage 5: saturation flags and quotient estimate
    logic                     lo_reg, lo_next;
    logic                     hi_reg, hi_next;
    logic [15:0]              u_reg, u_next;
    logic [CHAN_W-1:0]        qe_reg, qe_next;
    // stage 6: corrected, clamped value
    logic [CHAN_W-1:0]        q_reg, q_next;
    // stage 7: output register
    logic [CHAN_W-1:0]        out_reg, out_next;

    logic [T_W-QSHIFT-2:0]    u_full;
    logic [23:0]              u257;
    logic [15:0]              qe255;
    logic [16:0]              rem;
    logic [CHAN_W-1:0]        q_corr;

    always_comb
    begin
        x_next   = use_lin ? SRGB_TO_LIN[x_in] : x_in;
        y_next   = use_lin ? SRGB_TO_LIN[y_in] : y_in;

        xy_next  = x_reg * y_reg;
        k2x_next = coef.k2 * $signed({1'b0, x_reg});
        k3y_next = coef.k3 * $signed({1'b0, y_reg});

        m1_next  = coef.k1 * $signed({1'b0, xy_reg});
        s_next   = SUM_W'(k2x_reg) + SUM_W'(k3y_reg);

        // m1 + 255*s
        acc_next = ACC_W'(m1_reg) + (ACC_W'(s_reg) <<< 8) - ACC_W'(s_reg);

        t_next   = $signed({acc_reg[ACC_W-1], acc_reg, 1'b0}) + T_W'(coef.bias);

        // floor(t / (2*den)) = floor((t >> 17) / 255) for t >= 0
        u_full   = t_reg[T_W-2:QSHIFT];
        lo_next  = t_reg[T_W-1];
        hi_next  = !t_reg[T_W-1]
                   && ((|u_full[T_W-QSHIFT-2:16]) || (u_full[15:0] >= 16'(U_LIMIT)));
        u_next   = u_full[15:0];
        // u*257/65536 is u/255 or one below it
        u257     = (24'(u_full[15:0]) << 8) + 24'(u_full[15:0]);
        qe_next  = u257[23:16];

        qe255    = (16'(qe_reg) << 8) - 16'(qe_reg);
        rem      = {1'b0, u_reg} - {1'b0, qe255};
        q_corr   = qe_reg + CHAN_W'(rem >= 17'd255);
        if (lo_reg)
        begin
            q_next = '0;
        end
        else if (hi_reg)
        begin
            q_next = '1;
        end
        else
        begin
            q_next = q_corr;
        end

        out_next = use_lin ? LIN_TO_SRGB[q_reg] : q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (en[1])
        begin
            xy_reg  <= xy_next;
            k2x_reg <= k2x_next;
            k3y_reg <= k3y_next;
        end
        if (en[2])
        begin
            m1_reg <= m1_next;
            s_reg  <= s_next;
        end
        if (en[3])
        begin
            acc_reg <= acc_next;
        end
        if (en[4])
        begin
            t_reg <= t_next;
        end
        if (en[5])
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            u_reg  <= u_next;
            qe_reg <= qe_next;
        end
        if (en[6])
        begin
            q_reg <= q_next;
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

    assign res_out = out_reg;

endmodule

`default_nettype wire

// ----- src/arithmetic_pixel_composite_core.sv -----
// Top level of the arithmetic pixel composite: config registers, the stage
// valid/enable chain and four apc_channel datapaths (A, R, G, B).
// Depends on apc_pkg and apc_channel.
//
//   Port group  Dir  Payload
//   s_*         in   s_tdata[63:0]: pixel_first[31:0], pixel_second[63:32]
//   m_*         out  m_tdata[31:0]: pixel_out
//   cfg_*       in   cfg_index[2:0], cfg_data[23:0] (linear_mode uses bit 0)
//
// One beat per cycle in and out while m_tready is high; an accepted beat passes
// through the 8 register stages of the channel datapath (multiplies,
// accumulate, quotient estimate, correction, output) before it shows on m_*.
// Each stage holds when its successor is full and stalled; bubbles collapse,
// so a waiting result does not block new beats while any stage is empty.
// rst_n clears the stage valid bits and config registers; cfg_ready is always
// high. Config must be written only while the pipeline is empty; not enforced.
`default_nettype none

module arithmetic_pixel_composite_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] pixel_first, [63:32] pixel_second
    input  wire logic [2*apc_pkg::PIXEL_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] pixel_out
    output logic      [apc_pkg::PIXEL_W-1:0]   m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [apc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [apc_pkg::COEF_W-1:0]    cfg_data
);
    import apc_pkg::*;

    localparam int LAST = APC_STAGES - 1;

    logic signed [COEF_W-1:0] k1_reg, k1_next;
    logic signed [COEF_W-1:0] k2_reg, k2_next;
    logic signed [COEF_W-1:0] k3_reg, k3_next;
    logic signed [COEF_W-1:0] k4_reg, k4_next;
    logic                     lin_reg, lin_next;
    logic signed [BIAS_W-1:0] bias_reg, bias_next;

    logic [APC_STAGES-1:0]    valid_reg, valid_next;
    logic [APC_STAGES-1:0]    load;
    logic [APC_STAGES-1:0]    vin;
    stage_en_t                en;
    coef_t                    coef;

    // config write
    always_comb
    begin
        k1_next  = k1_reg;
        k2_next  = k2_reg;
        k3_next  = k3_reg;
        k4_next  = k4_reg;
        lin_next = lin_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_COEF_PRODUCT: k1_next  = $signed(cfg_data);
                CFG_COEF_FIRST:   k2_next  = $signed(cfg_data);
                CFG_COEF_SECOND:  k3_next  = $signed(cfg_data);
                CFG_COEF_OFFSET:  k4_next  = $signed(cfg_data);
                CFG_LINEAR_MODE:  lin_next = cfg_data[0];
                default:          ;
            endcase
        end
        // 2*65025*k4 + den, refreshed every cycle from k4
        bias_next = k4_reg * $signed({1'b0, 17'(BIAS_MULT)}) + $signed(BIAS_W'(ROUND_DEN));
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg  <= '0;
            k2_reg  <= '0;
            k3_reg  <= '0;
            k4_reg  <= '0;
            lin_reg <= 1'b0;
        end
        else
        begin
            k1_reg  <= k1_next;
            k2_reg  <= k2_next;
            k3_reg  <= k3_next;
            k4_reg  <= k4_next;
            lin_reg <= lin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bias_reg <= bias_next;
    end

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        vin        = {valid_reg[LAST-1:0], s_tvalid};
        en         = load & vin;
        valid_next = (load & vin) | (~load & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[LAST];

    assign coef.k1   = k1_reg;
    assign coef.k2   = k2_reg;
    assign coef.k3   = k3_reg;
    assign coef.bias = bias_reg;

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_chan
        apc_channel u_chan (
            .clk     (clk),
            .en      (en),
            .coef    (coef),
            .use_lin ((c == NUM_CHAN - 1) ? 1'b0 : lin_reg),
            .x_in    (s_tdata[c*CHAN_W +: CHAN_W]),
            .y_in    (s_tdata[PIXEL_W + c*CHAN_W +: CHAN_W]),
            .res_out (m_tdata[c*CHAN_W +: CHAN_W])
        );
    end

    // an empty output stage always lets a new beat in
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat lost at stage 0");

    // a held stage keeps its beat
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg & ~load)) == $past(valid_reg & ~load)))
        else $error("stalled stage dropped its beat");

endmodule

`default_nettype wire
